// ----- hw/rtl/rms_pkg.sv -----
// ----------------------------------------------------------------------------
// rms_pkg
// Shared types and constants of the rate-monotonic scheduler core.
// ----------------------------------------------------------------------------
package rms_pkg;

    localparam int TASK_SLOTS       = 4;
    localparam int NUM_TASKS_DEF    = 4;
    localparam int TIME_WIDTH_DEF   = 16;
    localparam int REG_W            = 16;
    localparam int APB_DATA_W       = 32;
    localparam int PADDR_W          = 5;
    localparam int REG_IDX_W        = 3;
    localparam int TASK_IDX_W       = 2;
    localparam int MASK_W           = TASK_SLOTS;

    localparam logic [REG_W-1:0] PERIOD_RESET = 16'hFFFF;
    localparam logic [REG_W-1:0] BUDGET_RESET = 16'h0000;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PERIOD_A = 3'd0,
        REG_BUDGET_A = 3'd1,
        REG_PERIOD_B = 3'd2,
        REG_BUDGET_B = 3'd3,
        REG_PERIOD_C = 3'd4,
        REG_BUDGET_C = 3'd5,
        REG_PERIOD_D = 3'd6,
        REG_BUDGET_D = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [TASK_SLOTS-1:0][REG_W-1:0] period;
        logic [TASK_SLOTS-1:0][REG_W-1:0] budget;
    } t_task_cfg;

    typedef struct packed {
        logic [TASK_IDX_W-1:0] running_task;
        logic                  idle;
        logic                  segment_start;
        logic [MASK_W-1:0]     released_mask;
    } t_result;

endpackage

// ----- hw/rtl/rms_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// rms_cfg_regs
// Period and budget registers of the four task slots behind an APB-style port.
// ----------------------------------------------------------------------------
module rms_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rms_pkg::PADDR_W-1:0]       paddr,
    input  logic [rms_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [rms_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output rms_pkg::t_task_cfg                o_cfg
);
    import rms_pkg::*;

    logic [REG_W-1:0] r_period [TASK_SLOTS];
    logic [REG_W-1:0] r_budget [TASK_SLOTS];
    logic [REG_W-1:0] w_rdata;
    logic [REG_W-1:0] w_wdata;
    logic             w_wr;
    t_reg_idx         w_idx;

    assign pready  = 1'b1;
    assign w_wr    = psel & penable & pwrite;
    assign w_idx   = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_wdata = pwdata[REG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TASK_SLOTS; t++) begin
                r_period[t] <= PERIOD_RESET;
                r_budget[t] <= BUDGET_RESET;
            end
        end else if (w_wr) begin
            case (w_idx)
                REG_PERIOD_A: r_period[0] <= w_wdata;
                REG_BUDGET_A: r_budget[0] <= w_wdata;
                REG_PERIOD_B: r_period[1] <= w_wdata;
                REG_BUDGET_B: r_budget[1] <= w_wdata;
                REG_PERIOD_C: r_period[2] <= w_wdata;
                REG_BUDGET_C: r_budget[2] <= w_wdata;
                REG_PERIOD_D: r_period[3] <= w_wdata;
                REG_BUDGET_D: r_budget[3] <= w_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_PERIOD_A: w_rdata = r_period[0];
            REG_BUDGET_A: w_rdata = r_budget[0];
            REG_PERIOD_B: w_rdata = r_period[1];
            REG_BUDGET_B: w_rdata = r_budget[1];
            REG_PERIOD_C: w_rdata = r_period[2];
            REG_BUDGET_C: w_rdata = r_budget[2];
            REG_PERIOD_D: w_rdata = r_period[3];
            REG_BUDGET_D: w_rdata = r_budget[3];
            default:      w_rdata = '0;
        endcase
    end

    assign prdata = {{(APB_DATA_W-REG_W){1'b0}}, w_rdata};

    always_comb begin
        for (int t = 0; t < TASK_SLOTS; t++) begin
            o_cfg.period[t] = r_period[t];
            o_cfg.budget[t] = r_budget[t];
        end
    end

endmodule

// ----- hw/rtl/rms_sched.sv -----
// ----------------------------------------------------------------------------
// rms_sched
// Per-task release countdowns and remaining work, shortest-period pick of
// the runner and the result of one tick.
// ----------------------------------------------------------------------------
module rms_sched #(
    parameter int NUM_TASKS  = rms_pkg::NUM_TASKS_DEF,
    parameter int TIME_WIDTH = rms_pkg::TIME_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_restart,
    input  rms_pkg::t_task_cfg i_cfg,
    output rms_pkg::t_result   o_result
);
    import rms_pkg::*;

    logic [TIME_WIDTH-1:0] r_rem [NUM_TASKS];
    logic [TIME_WIDTH-1:0] r_ttr [NUM_TASKS];
    logic [TIME_WIDTH-1:0] n_rem [NUM_TASKS];
    logic [TIME_WIDTH-1:0] n_ttr [NUM_TASKS];
    logic [TIME_WIDTH-1:0] w_per [NUM_TASKS];
    logic [TIME_WIDTH-1:0] w_bud [NUM_TASKS];
    logic                  r_started;
    logic                  r_prev_valid;
    logic [TASK_IDX_W-1:0] r_prev_idx;
    logic                  n_prev_valid;
    logic [TASK_IDX_W-1:0] n_prev_idx;
    logic                  w_go;
    logic                  w_run;
    logic [TASK_IDX_W-1:0] w_run_idx;
    logic [TIME_WIDTH-1:0] w_best;
    logic [MASK_W-1:0]     w_mask;

    always_comb begin
        for (int t = 0; t < NUM_TASKS; t++) begin
            w_per[t] = TIME_WIDTH'(i_cfg.period[t]);
            w_bud[t] = TIME_WIDTH'(i_cfg.budget[t]);
        end
    end

    assign w_go = i_restart | r_started;

    always_comb begin
        n_rem        = r_rem;
        n_ttr        = r_ttr;
        n_prev_valid = r_prev_valid;
        n_prev_idx   = r_prev_idx;
        w_mask       = '0;
        w_run        = 1'b0;
        w_run_idx    = '0;
        w_best       = '0;
        o_result     = '0;
        o_result.idle = 1'b1;
        if (w_go) begin
            // release or reload
            for (int t = 0; t < NUM_TASKS; t++) begin
                if (i_restart) begin
                    n_rem[t] = w_bud[t];
                    n_ttr[t] = w_per[t];
                end else if (w_per[t] != '0) begin
                    if (r_ttr[t] <= TIME_WIDTH'(1)) begin
                        n_ttr[t]  = w_per[t];
                        n_rem[t]  = w_bud[t];
                        w_mask[t] = 1'b1;
                    end else begin
                        n_ttr[t] = r_ttr[t] - TIME_WIDTH'(1);
                    end
                end
            end
            // shortest period wins, lower index on ties
            for (int t = 0; t < NUM_TASKS; t++) begin
                if (n_rem[t] != '0 && (!w_run || w_per[t] < w_best)) begin
                    w_run     = 1'b1;
                    w_run_idx = TASK_IDX_W'(t);
                    w_best    = w_per[t];
                end
            end
            for (int t = 0; t < NUM_TASKS; t++) begin
                if (w_run && w_run_idx == TASK_IDX_W'(t)) begin
                    n_rem[t] = n_rem[t] - TIME_WIDTH'(1);
                end
            end
            n_prev_valid = w_run;
            n_prev_idx   = w_run_idx;
            o_result.running_task  = w_run_idx;
            o_result.idle          = ~w_run;
            o_result.segment_start = w_run & (i_restart | (|w_mask) | ~r_prev_valid
                                              | (w_run_idx != r_prev_idx));
            o_result.released_mask = w_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started    <= 1'b0;
            r_prev_valid <= 1'b0;
            r_prev_idx   <= '0;
            for (int t = 0; t < NUM_TASKS; t++) begin
                r_rem[t] <= '0;
                r_ttr[t] <= '0;
            end
        end else if (i_accept) begin
            r_started    <= w_go;
            r_prev_valid <= n_prev_valid;
            r_prev_idx   <= n_prev_idx;
            r_rem        <= n_rem;
            r_ttr        <= n_ttr;
        end
    end

endmodule

// ----- hw/rtl/rms_out_buf.sv -----
// ----------------------------------------------------------------------------
// rms_out_buf
// Result register with a skid entry, so a tick is taken while a result waits.
// ----------------------------------------------------------------------------
module rms_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  rms_pkg::t_result i_data,
    input  logic             i_out_stall,
    output logic             o_valid,
    output rms_pkg::t_result o_data,
    output logic             o_full
);
    import rms_pkg::*;

    logic    r_valid;
    logic    r_skid_valid;
    t_result r_data;
    t_result r_skid;
    logic    n_valid;
    logic    n_skid_valid;
    t_result n_data;
    t_result n_skid;
    logic    w_take;

    assign w_take = r_valid & ~i_out_stall;

    always_comb begin
        n_valid      = r_valid;
        n_skid_valid = r_skid_valid;
        n_data       = r_data;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (w_take) begin
                n_data       = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_load) begin
            if (!r_valid || w_take) begin
                n_data  = i_data;
                n_valid = 1'b1;
            end else begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end
        end else if (w_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_valid      <= n_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_skid <= n_skid;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_full  = r_skid_valid;

endmodule

// ----- hw/rtl/rate_monotonic_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// rate_monotonic_scheduler_core
// Preemptive rate-monotonic scheduler, one time tick per input transfer.
// The result of a tick is registered in the output buffer on its transfer.
// Throughput: one tick per cycle while the input is not stalled.
// A two-entry result buffer takes one more tick while a result waits on a stall.
// Reset: synchronous, active low; idle until the first restart tick.
// ----------------------------------------------------------------------------
module rate_monotonic_scheduler_core #(
    parameter int NUM_TASKS  = rms_pkg::NUM_TASKS_DEF,
    parameter int TIME_WIDTH = rms_pkg::TIME_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_restart,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [rms_pkg::TASK_IDX_W-1:0]      o_running_task,
    output logic                                o_idle,
    output logic                                o_segment_start,
    output logic [rms_pkg::MASK_W-1:0]          o_released_mask,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rms_pkg::PADDR_W-1:0]         paddr,
    input  logic [rms_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [rms_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import rms_pkg::*;

    t_task_cfg w_cfg;
    t_result   w_result;
    t_result   w_out;
    logic      w_accept;
    logic      w_full;

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid & ~w_full;

    rms_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rms_sched #(
        .NUM_TASKS  (NUM_TASKS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_sched (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_restart (i_restart),
        .i_cfg     (w_cfg),
        .o_result  (w_result)
    );

    rms_out_buf u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_accept),
        .i_data      (w_result),
        .i_out_stall (i_out_stall),
        .o_valid     (o_out_valid),
        .o_data      (w_out),
        .o_full      (w_full)
    );

    assign o_running_task  = w_out.running_task;
    assign o_idle          = w_out.idle;
    assign o_segment_start = w_out.segment_start;
    assign o_released_mask = w_out.released_mask;

endmodule

// ----- hw/rtl/rms_checker.sv -----
// ----------------------------------------------------------------------------
// rms_checker
// Port-level checks of the scheduler core, attached by bind.
// ----------------------------------------------------------------------------
module rms_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [rms_pkg::TASK_IDX_W-1:0] o_running_task,
    input logic                           o_idle,
    input logic                           o_segment_start,
    input logic [rms_pkg::MASK_W-1:0]     o_released_mask
);
    import rms_pkg::*;

    // idle tick shows task zero and no new interval
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_idle) |-> (o_running_task == '0 && !o_segment_start))
        else $error("idle result with runner or segment start");

    // any release on a running tick opens an interval
    a_release_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_idle && o_released_mask != '0) |-> o_segment_start)
        else $error("release without segment start");

    // input back-pressure only when a result is held
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no pending result");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_running_task)
            && $stable(o_idle) && $stable(o_segment_start) && $stable(o_released_mask)))
        else $error("stalled result changed");

endmodule

bind rate_monotonic_scheduler_core rms_checker u_rms_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_running_task  (o_running_task),
    .o_idle          (o_idle),
    .o_segment_start (o_segment_start),
    .o_released_mask (o_released_mask)
);

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rate_monotonic_scheduler_core. A queue of ticks,
// each with its restart flag, feeds a clocked driver. A predictor keeps its
// own copy of the task counters and the register values, and works out the
// scheduling decision of every accepted tick. A clocked monitor compares each
// result transfer with the oldest prediction. Both channels idle at random.
// Register settings change between phases while the block is drained.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rms_pkg::*;

    localparam int TASKS       = NUM_TASKS_DEF;
    localparam int IDLE_RUNNER = 4;
    localparam int LIMIT       = 200000;
    localparam int RANDOM_TICKS = 950;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_restart = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [TASK_IDX_W-1:0] o_running_task;
    logic                  o_idle;
    logic                  o_segment_start;
    logic [MASK_W-1:0]     o_released_mask;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    rate_monotonic_scheduler_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_restart       (i_restart),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_running_task  (o_running_task),
        .o_idle          (o_idle),
        .o_segment_start (o_segment_start),
        .o_released_mask (o_released_mask),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow registers and scheduler state
    logic [REG_W-1:0] period_cfg [TASKS] = '{default: PERIOD_RESET};
    logic [REG_W-1:0] budget_cfg [TASKS] = '{default: BUDGET_RESET};
    logic [REG_W-1:0] work_left  [TASKS] = '{default: '0};
    logic [REG_W-1:0] countdown  [TASKS] = '{default: '0};
    int               prev_runner = IDLE_RUNNER;
    bit               started = 1'b0;

    logic    tick_q [$];
    t_result sched_q [$];
    int      mismatches = 0;
    int      cycles = 0;
    bit      no_gaps = 1'b0;

    function automatic t_result schedule_tick(input logic restart);
        t_result r;
        logic [MASK_W-1:0] mask;
        int runner;
        logic seg;
        r = '0;
        mask = '0;
        runner = IDLE_RUNNER;
        seg = 1'b0;
        if (!restart && !started) begin
            r.idle = 1'b1;
            return r;
        end
        if (restart) begin
            started = 1'b1;
            for (int i = 0; i < TASKS; i++) begin
                work_left[i] = budget_cfg[i];
                countdown[i] = period_cfg[i];
            end
        end else begin
            for (int i = 0; i < TASKS; i++) begin
                if (period_cfg[i] != '0) begin
                    if (countdown[i] <= 1) begin
                        countdown[i] = period_cfg[i];
                        work_left[i] = budget_cfg[i];
                        mask[i] = 1'b1;
                    end else begin
                        countdown[i] = countdown[i] - 1'b1;
                    end
                end
            end
        end
        // shortest period wins, lower index on ties
        for (int i = 0; i < TASKS; i++) begin
            if (work_left[i] != '0 &&
                (runner == IDLE_RUNNER || period_cfg[i] < period_cfg[runner]))
                runner = i;
        end
        if (runner != IDLE_RUNNER) begin
            work_left[runner] = work_left[runner] - 1'b1;
            seg = restart || (mask != '0) || (runner != prev_runner);
        end
        prev_runner = runner;
        r.running_task  = (runner == IDLE_RUNNER) ? '0 : runner[TASK_IDX_W-1:0];
        r.idle          = (runner == IDLE_RUNNER);
        r.segment_start = seg;
        r.released_mask = mask;
        return r;
    endfunction

    // tick driver
    always @(posedge i_clk) begin
        bit take;
        t_result pred;
        take = i_in_valid && !o_in_stall;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (take) begin
                pred = schedule_tick(i_restart);
                sched_q = {sched_q, pred};
            end
            if (take || !i_in_valid) begin
                if (tick_q.size() > 0 && (no_gaps || $urandom_range(99) >= 28)) begin
                    i_in_valid <= 1'b1;
                    i_restart  <= tick_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        got = '{o_running_task, o_idle, o_segment_start, o_released_mask};
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (sched_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: task %0d idle %0b seg %0b mask %h",
                                 got.running_task, got.idle, got.segment_start,
                                 got.released_mask);
                end else begin
                    want = sched_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected task %0d idle %0b seg %0b mask %h, got task %0d idle %0b seg %0b mask %h",
                                     want.running_task, want.idle, want.segment_start,
                                     want.released_mask, got.running_task, got.idle,
                                     got.segment_start, got.released_mask);
                    end
                end
            end
            i_out_stall <= !no_gaps && ($urandom_range(99) < 28);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic reg_write(input t_reg_idx idx, input logic [REG_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= {16'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx[0])
            budget_cfg[idx[REG_IDX_W-1:1]] = val;
        else
            period_cfg[idx[REG_IDX_W-1:1]] = val;
    endtask

    task automatic drain();
        while (tick_q.size() != 0 || i_in_valid || sched_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic queue_tick(input logic restart);
        tick_q = {tick_q, restart};
    endtask

    task automatic push_ticks(input logic restart_first, input int n, input int restart_odds);
        queue_tick(restart_first);
        for (int i = 1; i < n; i++)
            queue_tick($urandom_range(restart_odds - 1) == 0);
    endtask

    function automatic logic [REG_W-1:0] pick_period();
        int roll;
        roll = $urandom_range(9);
        if (roll < 6) return REG_W'($urandom_range(16, 1));
        if (roll == 6) return '0;
        if (roll == 7) return '1;
        return REG_W'($urandom);
    endfunction

    function automatic logic [REG_W-1:0] pick_budget();
        int roll;
        roll = $urandom_range(9);
        if (roll < 6) return REG_W'($urandom_range(6));
        if (roll == 6) return '0;
        if (roll == 7) return '1;
        return REG_W'($urandom);
    endfunction

    initial begin
        int sent;
        int phase;
        int n;
        sent = 0;
        phase = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ticks before the first restart stay idle
        queue_tick(1'b0);
        queue_tick(1'b0);
        drain();

        // zero period on c, zero budget on d
        reg_write(REG_PERIOD_A, 16'd4);
        reg_write(REG_BUDGET_A, 16'd1);
        reg_write(REG_PERIOD_B, 16'd6);
        reg_write(REG_BUDGET_B, 16'd2);
        reg_write(REG_PERIOD_C, 16'd0);
        reg_write(REG_BUDGET_C, 16'd3);
        reg_write(REG_PERIOD_D, 16'd5);
        reg_write(REG_BUDGET_D, 16'd0);
        push_ticks(1'b1, 13, 1000);
        drain();

        // change while running: c countdown stands at zero, tie between b and c
        reg_write(REG_PERIOD_C, 16'd3);
        reg_write(REG_PERIOD_B, 16'd3);
        reg_write(REG_BUDGET_A, 16'hFFFF);
        reg_write(REG_PERIOD_A, 16'hFFFF);
        push_ticks(1'b0, 8, 1000);
        drain();

        while (sent < RANDOM_TICKS) begin
            for (int k = 0; k < 2 * TASKS; k++) begin
                if (phase == 0 || $urandom_range(1))
                    reg_write(t_reg_idx'(k), k[0] ? pick_budget() : pick_period());
            end
            no_gaps = (phase == 5);
            n = no_gaps ? 150 : $urandom_range(80, 20);
            push_ticks($urandom_range(9) < 7, n, 50);
            sent += n;
            phase++;
            drain();
        end
        no_gaps = 1'b0;

        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && sched_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
